@@ src/rsi_pkg.sv @@
// Shared types and constants for the radix string to 64-bit integer converter.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package rsi_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int BASE_WIDTH = 6;
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH = 6;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_BASE_SELECT = 1'b0,
		REG_SIGNED_MODE = 1'b1
	} cfg_reg_t;

	localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_WIDTH-1:0] BASE_OCT = 6'd8;
	localparam logic [BASE_WIDTH-1:0] BASE_DEC = 6'd10;
	localparam logic [BASE_WIDTH-1:0] BASE_HEX = 6'd16;
	localparam logic [BASE_WIDTH-1:0] BASE_MAX = 6'd36;
	localparam logic [BASE_WIDTH-1:0] NO_DIGIT = 6'd63;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DIG0 = 8'h30;
	localparam logic [7:0] CH_DIG9 = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5A;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X = 8'h58;

	localparam logic [63:0] SGN_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SGN_NEG_LIMIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] UNS_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic       start_req;
		logic [7:0] char_byte;
	} char_item_t;

	typedef struct packed {
		logic [63:0]            value;
		logic                   overflow;
		logic [COUNT_WIDTH-1:0] consumed_count;
	} result_item_t;

	typedef struct packed {
		logic                  is_space;
		logic                  is_plus;
		logic                  is_minus;
		logic                  is_zero;
		logic                  is_x;
		logic [BASE_WIDTH-1:0] digit;
	} char_class_t;

endpackage

@@ src/rsi_char_decode.sv @@
// Character classifier: whitespace, sign, prefix characters and digit value.
// Depends on rsi_pkg for character constants and the class struct.
`timescale 1ns / 1ps

module rsi_char_decode (
	input  logic [7:0]          char_byte,
	output rsi_pkg::char_class_t char_class
);

	logic [7:0] num_off;
	logic [7:0] low_off;
	logic [7:0] up_off;

	always_comb begin
		num_off = char_byte - rsi_pkg::CH_DIG0;
		low_off = char_byte - rsi_pkg::CH_LOW_A + 8'd10;
		up_off = char_byte - rsi_pkg::CH_UP_A + 8'd10;

		char_class.is_space = (char_byte == rsi_pkg::CH_SPACE) ||
			((char_byte >= rsi_pkg::CH_TAB) && (char_byte <= rsi_pkg::CH_CR));
		char_class.is_plus = (char_byte == rsi_pkg::CH_PLUS);
		char_class.is_minus = (char_byte == rsi_pkg::CH_MINUS);
		char_class.is_zero = (char_byte == rsi_pkg::CH_DIG0);
		char_class.is_x = (char_byte == rsi_pkg::CH_LOW_X) || (char_byte == rsi_pkg::CH_UP_X);

		if ((char_byte >= rsi_pkg::CH_DIG0) && (char_byte <= rsi_pkg::CH_DIG9)) begin
			char_class.digit = num_off[rsi_pkg::BASE_WIDTH-1:0];
		end else if ((char_byte >= rsi_pkg::CH_LOW_A) && (char_byte <= rsi_pkg::CH_LOW_Z)) begin
			char_class.digit = low_off[rsi_pkg::BASE_WIDTH-1:0];
		end else if ((char_byte >= rsi_pkg::CH_UP_A) && (char_byte <= rsi_pkg::CH_UP_Z)) begin
			char_class.digit = up_off[rsi_pkg::BASE_WIDTH-1:0];
		end else begin
			char_class.digit = rsi_pkg::NO_DIGIT;
		end
	end

endmodule

@@ src/rsi_convert_core.sv @@
// Conversion state machine with the accumulate, range check and result build.
// Depends on rsi_pkg and rsi_char_decode.
`timescale 1ns / 1ps

module rsi_convert_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step_en,
	input  rsi_pkg::char_item_t               item,
	input  logic [rsi_pkg::BASE_WIDTH-1:0]    base_select,
	input  logic                              signed_mode,
	output logic                              emit,
	output rsi_pkg::result_item_t             result
);

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_LEAD   = 5'b00010,
		PH_PREFIX = 5'b00100,
		PH_ZERO   = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	localparam int CW = rsi_pkg::COUNT_WIDTH;
	localparam int BW = rsi_pkg::BASE_WIDTH;

	phase_t          phase_q;
	logic [63:0]     acc_q;
	logic            neg_q;
	logic [BW-1:0]   base_q;
	logic [CW-1:0]   pos_q;
	logic            sat_q;

	rsi_pkg::char_class_t cls;

	phase_t          ph_e;
	logic [63:0]     acc_e;
	logic            neg_e;
	logic [BW-1:0]   base_e;
	logic [CW-1:0]   pos_e;
	logic            sat_e;
	logic [CW-1:0]   pos_inc;

	phase_t          ph_n;
	logic [63:0]     acc_n;
	logic            neg_n;
	logic [BW-1:0]   base_n;
	logic [CW-1:0]   pos_n;
	logic            sat_n;
	logic            take_digit;
	logic            take_prefix;
	logic [69:0]     prod;
	logic [63:0]     limit;
	logic [63:0]     sat_value;

	rsi_char_decode u_decode (
		.char_byte  (item.char_byte),
		.char_class (cls)
	);

	// state as seen by this character, after a start
	always_comb begin
		if (item.start_req) begin
			ph_e = PH_LEAD;
			acc_e = '0;
			neg_e = 1'b0;
			sat_e = 1'b0;
			pos_e = '0;
			base_e = (base_select > rsi_pkg::BASE_MAX) ? rsi_pkg::BASE_MAX : base_select;
		end else begin
			ph_e = phase_q;
			acc_e = acc_q;
			neg_e = neg_q;
			sat_e = sat_q;
			pos_e = pos_q;
			base_e = base_q;
		end
		pos_inc = (pos_e == {CW{1'b1}}) ? pos_e : pos_e + 1'b1;
	end

	always_comb begin
		ph_n = ph_e;
		acc_n = acc_e;
		neg_n = neg_e;
		base_n = base_e;
		pos_n = pos_e;
		sat_n = sat_e;
		take_digit = 1'b0;
		take_prefix = 1'b0;
		emit = 1'b0;

		case (ph_e)
			PH_LEAD: begin
				if (cls.is_space) begin
					pos_n = pos_inc;
				end else if (signed_mode && (cls.is_plus || cls.is_minus)) begin
					neg_n = cls.is_minus;
					pos_n = pos_inc;
					ph_n = PH_PREFIX;
				end else begin
					take_prefix = 1'b1;
				end
			end
			PH_PREFIX: begin
				take_prefix = 1'b1;
			end
			PH_ZERO: begin
				if (cls.is_x) begin
					base_n = rsi_pkg::BASE_HEX;
					pos_n = pos_inc;
					ph_n = PH_DIGITS;
				end else begin
					if (base_e == rsi_pkg::BASE_AUTO) begin
						base_n = rsi_pkg::BASE_OCT;
					end
					ph_n = PH_DIGITS;
					take_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				take_digit = 1'b1;
			end
			default: begin
			end
		endcase

		if (take_prefix) begin
			if (cls.is_zero && ((base_e == rsi_pkg::BASE_AUTO) ||
				(base_e == rsi_pkg::BASE_HEX))) begin
				pos_n = pos_inc;
				ph_n = PH_ZERO;
			end else begin
				if (base_e == rsi_pkg::BASE_AUTO) begin
					base_n = rsi_pkg::BASE_DEC;
				end
				ph_n = PH_DIGITS;
				take_digit = 1'b1;
			end
		end

		if (!signed_mode) begin
			limit = rsi_pkg::UNS_LIMIT;
		end else if (neg_n) begin
			limit = rsi_pkg::SGN_NEG_LIMIT;
		end else begin
			limit = rsi_pkg::SGN_POS_LIMIT;
		end
		prod = 70'(acc_e) * 70'(base_n) + 70'(cls.digit);

		if (take_digit) begin
			if ((base_n == rsi_pkg::BASE_AUTO) || (cls.digit >= base_n)) begin
				emit = 1'b1;
				ph_n = PH_IDLE;
			end else begin
				if (!sat_e) begin
					if (prod > 70'(limit)) begin
						sat_n = 1'b1;
					end else begin
						acc_n = prod[63:0];
					end
				end
				pos_n = pos_inc;
			end
		end
	end

	always_comb begin
		if (!signed_mode) begin
			sat_value = rsi_pkg::UNS_LIMIT;
		end else if (neg_e) begin
			sat_value = rsi_pkg::SGN_NEG_LIMIT;
		end else begin
			sat_value = rsi_pkg::SGN_POS_LIMIT;
		end
		if (sat_e) begin
			result.value = sat_value;
		end else if (neg_e) begin
			result.value = 64'd0 - acc_e;
		end else begin
			result.value = acc_e;
		end
		result.overflow = sat_e;
		result.consumed_count = pos_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q <= '0;
			neg_q <= 1'b0;
			base_q <= '0;
			pos_q <= '0;
			sat_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= ph_n;
			acc_q <= acc_n;
			neg_q <= neg_n;
			base_q <= base_n;
			pos_q <= pos_n;
			sat_q <= sat_n;
		end
	end

endmodule

@@ src/radix_string_to_int64.sv @@
// Output path: the ending character is registered in item_s1, then its result in result_q.
// Throughput: one character per cycle, set by the state update loop
// (accumulate of 64 by 6 bits plus range compare); stalls only on a held result.
// Reset: asynchronous, active low; clears the pipeline and conversion state,
// base_select returns to 10 and signed_mode to 1.
// Top level: input, configuration and result registers around rsi_convert_core (rsi_pkg).
`timescale 1ns / 1ps

module radix_string_to_int64 (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   char_valid,
	output logic                                   char_ready,
	input  rsi_pkg::char_item_t                    char_item,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output rsi_pkg::result_item_t                  result_item,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rsi_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [rsi_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

	logic                               valid_s1;
	rsi_pkg::char_item_t                item_s1;
	logic [rsi_pkg::BASE_WIDTH-1:0]     base_select_q;
	logic                               signed_mode_q;
	logic                               result_valid_q;
	rsi_pkg::result_item_t              result_q;
	logic                               emit;
	rsi_pkg::result_item_t              core_result;
	logic                               stall;
	logic                               step_en;

	assign cfg_ready = 1'b1;

	// hold the character while a held result blocks its ending transaction
	assign stall = emit && result_valid_q && !result_ready;
	assign step_en = valid_s1 && !stall;
	assign char_ready = !valid_s1 || step_en;

	assign result_valid = result_valid_q;
	assign result_item = result_q;

	rsi_convert_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.item        (item_s1),
		.base_select (base_select_q),
		.signed_mode (signed_mode_q),
		.emit        (emit),
		.result      (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_select_q <= rsi_pkg::BASE_DEC;
			signed_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rsi_pkg::REG_BASE_SELECT: base_select_q <= cfg_data;
				rsi_pkg::REG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && char_ready) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			item_s1 <= char_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step_en && emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && emit) begin
			result_q <= core_result;
		end
	end

endmodule

@@ test/tb_radix_string_to_int64.sv @@
// Self-checking testbench for radix_string_to_int64: drives characters, configuration
// writes and result back-pressure, checking results against in-bench or table values.
// Depends on rsi_pkg and the radix_string_to_int64 RTL only.
`timescale 1ns / 1ps

module tb_radix_string_to_int64;

	localparam int QUIET_LIMIT = 3000;
	localparam logic [7:0] CH_DOT = 8'h2E;

	typedef enum logic [4:0] {
		SCAN_IDLE      = 5'b00001,
		SCAN_LEAD      = 5'b00010,
		SCAN_SIGN_SEEN = 5'b00100,
		SCAN_ZERO      = 5'b01000,
		SCAN_DIGITS    = 5'b10000
	} scan_phase_t;

	typedef struct {
		logic [5:0]  base;
		bit          sgn;
		int          pad;
		string       text;
		bit          typed;
		logic [63:0] val;
		bit          ovf;
		logic [15:0] cnt;
	} case_row_t;

	case_row_t directed_rows [26] = '{
		'{6'd10, 1'b1, 0, "  -123", 1'b1, 64'hFFFF_FFFF_FFFF_FF85, 1'b0, 16'd6},
		'{6'd10, 1'b1, 0, "9223372036854775807", 1'b1, rsi_pkg::SGN_POS_LIMIT, 1'b0,
			16'd19},
		'{6'd10, 1'b1, 0, "9223372036854775808", 1'b1, rsi_pkg::SGN_POS_LIMIT, 1'b1,
			16'd19},
		'{6'd10, 1'b1, 0, "-9223372036854775808", 1'b1, rsi_pkg::SGN_NEG_LIMIT, 1'b0,
			16'd20},
		'{6'd10, 1'b1, 0, "-9223372036854775809", 1'b1, rsi_pkg::SGN_NEG_LIMIT, 1'b1,
			16'd20},
		'{6'd10, 1'b1, 0, "\011\012\013\014\015+42x", 1'b1, 64'd42, 1'b0, 16'd8},
		'{6'd10, 1'b1, 0, "+", 1'b1, 64'd0, 1'b0, 16'd1},
		'{6'd10, 1'b1, 0, "", 1'b1, 64'd0, 1'b0, 16'd0},
		'{6'd0, 1'b1, 0, "0x1F", 1'b1, 64'd31, 1'b0, 16'd4},
		'{6'd0, 1'b1, 0, "0X", 1'b1, 64'd0, 1'b0, 16'd2},
		'{6'd0, 1'b1, 0, "0xg", 1'b1, 64'd0, 1'b0, 16'd2},
		'{6'd0, 1'b1, 0, "017", 1'b1, 64'd15, 1'b0, 16'd3},
		'{6'd0, 1'b1, 0, "089", 1'b1, 64'd0, 1'b0, 16'd1},
		'{6'd0, 1'b1, 0, "-12", 1'b0, 64'd0, 1'b0, 16'd0},
		'{6'd16, 1'b1, 0, "0xff", 1'b1, 64'd255, 1'b0, 16'd4},
		'{6'd16, 1'b1, 0, "zz", 1'b1, 64'd0, 1'b0, 16'd0},
		'{6'd8, 1'b1, 0, "0777", 1'b1, 64'd511, 1'b0, 16'd4},
		'{6'd2, 1'b1, 0, "-101", 1'b0, 64'd0, 1'b0, 16'd0},
		'{6'd10, 1'b0, 0, "18446744073709551615", 1'b1, rsi_pkg::UNS_LIMIT, 1'b0, 16'd20},
		'{6'd10, 1'b0, 0, "18446744073709551616", 1'b1, rsi_pkg::UNS_LIMIT, 1'b1, 16'd20},
		'{6'd10, 1'b0, 0, "-5", 1'b1, 64'd0, 1'b0, 16'd0},
		'{6'd36, 1'b0, 0, "zZ", 1'b1, 64'd1295, 1'b0, 16'd2},
		'{6'd1, 1'b0, 0, "0001", 1'b1, 64'd0, 1'b0, 16'd3},
		'{6'd0, 1'b0, 0, "0xFFFFFFFFFFFFFFFF", 1'b1, rsi_pkg::UNS_LIMIT, 1'b0, 16'd18},
		'{6'd63, 1'b1, 0, "Zz", 1'b0, 64'd0, 1'b0, 16'd0},
		'{6'd37, 1'b1, 0, "-zzzzzzzzzzzzzz", 1'b0, 64'd0, 1'b0, 16'd0}
	};

	logic                                         clk = 1'b0;
	logic                                         arst_n = 1'b0;
	logic                                         char_valid = 1'b0;
	logic                                         char_ready;
	rsi_pkg::char_item_t                          char_item = '0;
	logic                                         result_valid;
	logic                                         result_ready = 1'b0;
	rsi_pkg::result_item_t                        result_item;
	logic                                         cfg_valid = 1'b0;
	logic                                         cfg_ready;
	logic [rsi_pkg::CFG_INDEX_WIDTH-1:0]          cfg_index = '0;
	logic [rsi_pkg::CFG_DATA_WIDTH-1:0]           cfg_data = '0;

	// in-bench copy of the converter state and its registers
	scan_phase_t  scan_phase = SCAN_IDLE;
	logic [63:0]  scan_acc = '0;
	bit           scan_neg = 1'b0;
	logic [5:0]   scan_base = '0;
	logic [15:0]  scan_count = '0;
	bit           scan_sat = 1'b0;
	logic [5:0]   cur_base = rsi_pkg::BASE_DEC;
	bit           cur_signed = 1'b1;

	rsi_pkg::result_item_t awaited_results [$];
	rsi_pkg::result_item_t typed_result;
	bit           use_typed = 1'b0;
	bit           fresh_string = 1'b0;
	int           errors = 0;
	int           sent_chars = 0;
	int           gap_odds = 0;
	int           stall_odds = 0;
	int           stall_left = 0;
	int           quiet_cycles = 0;

	radix_string_to_int64 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_item    (char_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] range_limit();
		if (!cur_signed)
			return rsi_pkg::UNS_LIMIT;
		return scan_neg ? rsi_pkg::SGN_NEG_LIMIT : rsi_pkg::SGN_POS_LIMIT;
	endfunction

	function automatic void bump_count();
		if (scan_count != 16'hFFFF)
			scan_count = scan_count + 16'd1;
	endfunction

	function automatic bit take_digit(input logic [7:0] c,
		output rsi_pkg::result_item_t r);
		logic [5:0]  d;
		logic [71:0] wide;
		r = '0;
		if (c >= rsi_pkg::CH_DIG0 && c <= rsi_pkg::CH_DIG9)
			d = 6'(c - rsi_pkg::CH_DIG0);
		else if (c >= rsi_pkg::CH_LOW_A && c <= rsi_pkg::CH_LOW_Z)
			d = 6'(c - rsi_pkg::CH_LOW_A + 8'd10);
		else if (c >= rsi_pkg::CH_UP_A && c <= rsi_pkg::CH_UP_Z)
			d = 6'(c - rsi_pkg::CH_UP_A + 8'd10);
		else
			d = rsi_pkg::NO_DIGIT;
		if (scan_base == rsi_pkg::BASE_AUTO || d >= scan_base) begin
			r.value = scan_sat ? range_limit() : (scan_neg ? 64'd0 - scan_acc : scan_acc);
			r.overflow = scan_sat;
			r.consumed_count = scan_count;
			scan_phase = SCAN_IDLE;
			return 1'b1;
		end
		if (!scan_sat) begin
			wide = 72'(scan_acc) * 72'(scan_base) + 72'(d);
			if (wide > 72'(range_limit()))
				scan_sat = 1'b1;
			else
				scan_acc = wide[63:0];
		end
		bump_count();
		return 1'b0;
	endfunction

	function automatic bit take_prefix(input logic [7:0] c,
		output rsi_pkg::result_item_t r);
		r = '0;
		if (c == rsi_pkg::CH_DIG0 &&
				(scan_base == rsi_pkg::BASE_AUTO || scan_base == rsi_pkg::BASE_HEX)) begin
			bump_count();
			scan_phase = SCAN_ZERO;
			return 1'b0;
		end
		if (scan_base == rsi_pkg::BASE_AUTO)
			scan_base = rsi_pkg::BASE_DEC;
		scan_phase = SCAN_DIGITS;
		return take_digit(c, r);
	endfunction

	function automatic bit convert_char(input rsi_pkg::char_item_t it,
		output rsi_pkg::result_item_t r);
		logic [7:0] c;
		c = it.char_byte;
		r = '0;
		if (it.start_req) begin
			scan_phase = SCAN_LEAD;
			scan_acc = '0;
			scan_neg = 1'b0;
			scan_sat = 1'b0;
			scan_count = '0;
			scan_base = cur_base > rsi_pkg::BASE_MAX ? rsi_pkg::BASE_MAX : cur_base;
		end
		case (scan_phase)
			SCAN_LEAD: begin
				if (c == rsi_pkg::CH_SPACE || (c >= rsi_pkg::CH_TAB && c <= rsi_pkg::CH_CR)) begin
					bump_count();
					return 1'b0;
				end
				if (cur_signed && (c == rsi_pkg::CH_PLUS || c == rsi_pkg::CH_MINUS)) begin
					scan_neg = (c == rsi_pkg::CH_MINUS);
					bump_count();
					scan_phase = SCAN_SIGN_SEEN;
					return 1'b0;
				end
				return take_prefix(c, r);
			end
			SCAN_SIGN_SEEN: return take_prefix(c, r);
			SCAN_ZERO: begin
				if (c == rsi_pkg::CH_LOW_X || c == rsi_pkg::CH_UP_X) begin
					scan_base = rsi_pkg::BASE_HEX;
					bump_count();
					scan_phase = SCAN_DIGITS;
					return 1'b0;
				end
				if (scan_base == rsi_pkg::BASE_AUTO)
					scan_base = rsi_pkg::BASE_OCT;
				scan_phase = SCAN_DIGITS;
				return take_digit(c, r);
			end
			SCAN_DIGITS: return take_digit(c, r);
			default: return 1'b0;
		endcase
	endfunction

	// check results first so that a result never meets an expectation from the same edge
	always @(posedge clk) begin
		rsi_pkg::result_item_t want;
		rsi_pkg::result_item_t pred;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: value %h overflow %0d count %0d",
						result_item.value, result_item.overflow, result_item.consumed_count);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (result_item.value !== want.value) begin
						$error("value: expected %h, got %h", want.value, result_item.value);
						errors++;
					end
					if (result_item.overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d", want.overflow,
							result_item.overflow);
						errors++;
					end
					if (result_item.consumed_count !== want.consumed_count) begin
						$error("consumed_count: expected %0d, got %0d", want.consumed_count,
							result_item.consumed_count);
						errors++;
					end
				end
			end
			if (char_valid && char_ready) begin
				if (convert_char(char_item, pred))
					awaited_results.push_back(use_typed ? typed_result : pred);
			end
			if (cfg_valid && cfg_ready) begin
				if (rsi_pkg::cfg_reg_t'(cfg_index) == rsi_pkg::REG_BASE_SELECT)
					cur_base = cfg_data;
				else
					cur_signed = cfg_data[0];
			end
		end
	end

	// result back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
			stall_left = $urandom_range(1, 15);
		result_ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if (!arst_n || (char_valid && char_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_radix_string_to_int64: done, errors");
			$finish;
		end
	end

	task automatic send_char(input rsi_pkg::char_item_t it);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_item <= it;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
	endtask

	task automatic emit(input logic [7:0] c);
		send_char(rsi_pkg::char_item_t'({fresh_string, c}));
		fresh_string = 1'b0;
		sent_chars++;
	endtask

	task automatic write_config(input logic [5:0] base, input bit sgn);
		cfg_valid <= 1'b1;
		cfg_index <= rsi_pkg::REG_BASE_SELECT;
		cfg_data <= base;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= rsi_pkg::REG_SIGNED_MODE;
		cfg_data <= {5'd0, sgn};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold until every result is in, then let the pipeline empty
	task automatic settle();
		char_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_number(input logic [5:0] bsel, input bit sgn);
		int radix;
		int ndig;
		int top;
		int v;
		logic [7:0] c;
		radix = bsel > rsi_pkg::BASE_MAX ? int'(rsi_pkg::BASE_MAX) : int'(bsel);
		fresh_string = 1'b1;
		repeat ($urandom_range(0, 2))
			emit($urandom_range(0, 5) == 0 ? rsi_pkg::CH_SPACE : 8'($urandom_range(9, 13)));
		if ((sgn || $urandom_range(0, 7) == 0) && $urandom_range(0, 2) != 0)
			emit($urandom_range(0, 1) ? rsi_pkg::CH_MINUS : rsi_pkg::CH_PLUS);
		if (radix == 0) begin
			case ($urandom_range(0, 2))
				0: begin
					emit(rsi_pkg::CH_DIG0);
					emit($urandom_range(0, 1) ? rsi_pkg::CH_LOW_X : rsi_pkg::CH_UP_X);
					radix = 16;
				end
				1: begin
					emit(rsi_pkg::CH_DIG0);
					radix = 8;
				end
				default: radix = 10;
			endcase
		end else if (radix == 16 && $urandom_range(0, 1)) begin
			emit(rsi_pkg::CH_DIG0);
			emit($urandom_range(0, 1) ? rsi_pkg::CH_LOW_X : rsi_pkg::CH_UP_X);
		end else if (radix == 8 && $urandom_range(0, 1)) begin
			emit(rsi_pkg::CH_DIG0);
		end
		top = radix <= 3 ? 66 : radix <= 7 ? 34 : radix <= 15 ? 24 : 18;
		ndig = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(1, top);
		for (int k = 0; k < ndig; k++) begin
			v = (k == 0 && $urandom_range(0, 3) == 0) ? radix - 1 : $urandom_range(0, radix - 1);
			emit(v < 10 ? 8'(rsi_pkg::CH_DIG0 + v) :
				8'(($urandom_range(0, 1) ? rsi_pkg::CH_LOW_A : rsi_pkg::CH_UP_A) + v - 10));
		end
		case ($urandom_range(0, 3))
			0: c = 8'h00;
			1: c = rsi_pkg::CH_SPACE;
			2: c = 8'($urandom_range(0, 255));
			default: c = radix >= 36 ? CH_DOT :
				radix >= 10 ? 8'(rsi_pkg::CH_LOW_A + radix - 10) : 8'(rsi_pkg::CH_DIG0 + radix);
		endcase
		emit(c);
	endtask

	initial begin
		int goal;
		int total;
		logic [5:0] base;
		bit sgn;
		logic [7:0] c;
		logic [5:0] phase_base [9];
		bit phase_sgn [9];
		phase_base = '{rsi_pkg::BASE_AUTO, rsi_pkg::BASE_HEX, 6'd2, rsi_pkg::BASE_MAX,
			rsi_pkg::BASE_OCT, rsi_pkg::BASE_DEC, rsi_pkg::BASE_DEC, rsi_pkg::BASE_AUTO,
			rsi_pkg::BASE_DEC};
		phase_sgn = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_odds = 4;
		stall_odds = 4;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].base != cur_base || directed_rows[i].sgn != cur_signed)
				write_config(directed_rows[i].base, directed_rows[i].sgn);
			use_typed = directed_rows[i].typed;
			typed_result = '{value: directed_rows[i].val, overflow: directed_rows[i].ovf,
				consumed_count: directed_rows[i].cnt};
			total = directed_rows[i].pad + directed_rows[i].text.len() + 1;
			for (int k = 0; k < total; k++) begin
				if (k < directed_rows[i].pad)
					c = rsi_pkg::CH_SPACE;
				else if (k < total - 1)
					c = directed_rows[i].text[k - directed_rows[i].pad];
				else
					c = 8'h00;
				send_char(rsi_pkg::char_item_t'({k == 0, c}));
			end
			settle();
			use_typed = 1'b0;
		end

		for (int p = 0; p < 9; p++) begin
			base = phase_base[p];
			sgn = phase_sgn[p];
			if (p == 6) begin
				base = 6'($urandom_range(0, 63));
				sgn = $urandom_range(0, 1);
			end
			gap_odds = p == 8 ? 0 : (p % 3 == 0 ? 0 : (p % 3 == 1 ? 8 : 3));
			stall_odds = p == 8 ? 0 : (p % 3 == 2 ? 0 : (p % 3 == 0 ? 3 : 8));
			write_config(base, sgn);
			goal = sent_chars + 100;
			while (sent_chars < goal) begin
				case ($urandom_range(0, 9))
					0: begin
						fresh_string = 1'b1;
						repeat ($urandom_range(1, 8)) begin
							emit(8'($urandom_range(0, 255)));
							fresh_string = ($urandom_range(0, 9) == 0);
						end
					end
					1: send_char(rsi_pkg::char_item_t'({1'b0, 8'($urandom_range(0, 255))}));
					default: send_number(base, sgn);
				endcase
			end
			// close any conversion still open before the next register write
			send_char(rsi_pkg::char_item_t'({1'b0, 8'h00}));
			settle();
		end

		repeat (10) @(posedge clk);
		if (errors == 0 && awaited_results.size() == 0)
			$display("tb_radix_string_to_int64: done, clean");
		else
			$display("tb_radix_string_to_int64: done, errors");
		$finish;
	end

endmodule
